### src/huffman_tree_walk_decoder_macros.svh
// Assertion macros for the tree-walk Huffman decoder.
// Clocked on i_clk and disabled while i_rst_n is low; no other dependencies.
`ifndef HUFFMAN_TREE_WALK_DECODER_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HTWD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HTWD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/htwd_pkg.sv
// Shared types and constants for the tree-walk Huffman decoder.
// No dependencies; imported by every module of the block.
package htwd_pkg;

    localparam int IDX_W     = 9;
    localparam int SYM_W     = 8;
    localparam int CNT_W     = 4;
    localparam int S_TDATA_W = 48;

    localparam logic            MODE_LOAD   = 1'b0;
    localparam logic            MODE_DECODE = 1'b1;
    localparam logic [CNT_W-1:0] BYTE_BITS  = 4'd8;

    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] sym;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } t_node;

    typedef struct packed {
        logic             is_load;
        logic [IDX_W-1:0] idx;
        t_node            node;
        logic [SYM_W-1:0] data;
        logic [CNT_W-1:0] nbits;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_FLUSH
    } t_back_state;

endpackage

### src/htwd_front.sv
// Front end: unpacks an accepted stream transfer and classifies it as a load or a decode.
// Depends on htwd_pkg.
module htwd_front
    import htwd_pkg::*;
(
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [S_TDATA_W-1:0] i_data,
    input  logic                 i_mode,
    output logic                 o_push,
    input  logic                 i_queue_ready,
    output t_cmd                 o_cmd
);

    logic [CNT_W-1:0] w_vbits;

    assign o_push  = i_valid;
    assign o_ready = i_queue_ready;
    assign w_vbits = i_data[47:44];

    always_comb begin
        o_cmd.is_load   = (i_mode == MODE_LOAD);
        o_cmd.idx       = i_data[8:0];
        o_cmd.node.leaf = i_data[9];
        o_cmd.node.sym  = i_data[17:10];
        o_cmd.node.lo   = i_data[26:18];
        o_cmd.node.hi   = i_data[35:27];
        o_cmd.data      = i_data[43:36];
        // clamp the bit count to one byte
        o_cmd.nbits     = (w_vbits > BYTE_BITS) ? BYTE_BITS : w_vbits;
    end

endmodule

### src/htwd_queue.sv
// Two-entry command queue between the front end and the tree walker.
// Depends on htwd_pkg.
module htwd_queue
    import htwd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       w_wr;
    logic       w_rd;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rp];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### src/htwd_back.sv
// Back end: node table memory, bit-serial tree walk and output register.
// Depends on htwd_pkg and huffman_tree_walk_decoder_macros.svh.
`include "huffman_tree_walk_decoder_macros.svh"

module htwd_back
    import htwd_pkg::*;
#(
    parameter int NODE_SLOTS = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_pop,
    input  t_cmd             i_cmd,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [SYM_W-1:0] o_m_tdata,
    output logic             o_m_tlast
);

    localparam int               AW    = $clog2(NODE_SLOTS);
    localparam logic [IDX_W:0]   SLOTS = (IDX_W+1)'(NODE_SLOTS);

    t_node            r_mem [NODE_SLOTS];
    t_node            r_q;
    t_node            r_cur,   n_cur;
    t_node            r_root,  n_root;
    logic             r_pend,  n_pend;
    logic [SYM_W-1:0] r_byte,  n_byte;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic             r_hold_v, n_hold_v;
    logic [SYM_W-1:0] r_hold_sym, n_hold_sym;
    logic             r_out_valid, n_out_valid;
    logic [SYM_W-1:0] r_out_sym,  n_out_sym;
    logic             r_out_last, n_out_last;
    t_back_state      r_state, n_state;

    logic             w_out_free;
    t_node            w_eff;
    logic             w_found;
    logic             w_have_bit;
    logic [IDX_W-1:0] w_child;
    logic             w_child_ok;
    logic             w_stall;
    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    logic             w_wr_en;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_eff      = r_pend ? (r_q.leaf ? r_root : r_q) : r_cur;
    assign w_found    = r_pend && r_q.leaf;
    assign w_have_bit = (r_cnt != '0);
    assign w_child    = r_byte[SYM_W-1] ? w_eff.hi : w_eff.lo;
    assign w_child_ok = ({1'b0, w_child} < SLOTS);
    assign w_stall    = w_found && r_hold_v && !w_out_free;
    assign w_rd_addr  = w_child[AW-1:0];
    assign w_wr_en    = (r_state == BK_IDLE) && i_valid && i_cmd.is_load &&
                        ({1'b0, i_cmd.idx} < SLOTS);
    assign w_rd_en    = (r_state == BK_WALK) && !w_stall && w_have_bit &&
                        !w_eff.leaf && w_child_ok;

    assign o_pop      = (r_state == BK_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_sym;
    assign o_m_tlast  = r_out_last;

    // node table: one write port for loads, one registered read port for the walk
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[i_cmd.idx[AW-1:0]] <= i_cmd.node;
        end
        if (w_rd_en) begin
            r_q <= r_mem[w_rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_valid && !i_cmd.is_load) begin
                    n_state = BK_WALK;
                end
            end
            BK_WALK: begin
                if (!w_stall && !w_have_bit) begin
                    n_state = BK_FLUSH;
                end
            end
            BK_FLUSH: begin
                if (!r_hold_v || w_out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        n_cur       = r_cur;
        n_root      = r_root;
        n_pend      = r_pend;
        n_byte      = r_byte;
        n_cnt       = r_cnt;
        n_hold_v    = r_hold_v;
        n_hold_sym  = r_hold_sym;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_sym   = r_out_sym;
        n_out_last  = r_out_last;
        case (r_state)
            BK_IDLE: begin
                if (i_valid) begin
                    if (i_cmd.is_load) begin
                        // a load always sends the walk back to the root
                        if (i_cmd.idx == '0) begin
                            n_root = i_cmd.node;
                            n_cur  = i_cmd.node;
                        end else begin
                            n_cur  = r_root;
                        end
                        n_pend = 1'b0;
                    end else begin
                        n_byte = i_cmd.data;
                        n_cnt  = i_cmd.nbits;
                    end
                end
            end
            BK_WALK: begin
                if (!w_stall) begin
                    if (w_found) begin
                        // release the previous symbol; it is not the last of this byte
                        if (r_hold_v) begin
                            n_out_valid = 1'b1;
                            n_out_sym   = r_hold_sym;
                            n_out_last  = 1'b0;
                        end
                        n_hold_v   = 1'b1;
                        n_hold_sym = r_q.sym;
                    end
                    if (w_have_bit) begin
                        n_byte = {r_byte[SYM_W-2:0], 1'b0};
                        n_cnt  = r_cnt - 4'd1;
                        if (w_eff.leaf) begin
                            n_cur  = w_eff;
                            n_pend = 1'b0;
                        end else if (w_child_ok) begin
                            n_pend = 1'b1;
                        end else begin
                            n_cur  = r_root;
                            n_pend = 1'b0;
                        end
                    end else begin
                        n_cur  = w_eff;
                        n_pend = 1'b0;
                    end
                end
            end
            BK_FLUSH: begin
                if (r_hold_v && w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_sym   = r_hold_sym;
                    n_out_last  = 1'b1;
                    n_hold_v    = 1'b0;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_root     <= n_root;
        r_byte     <= n_byte;
        r_hold_sym <= n_hold_sym;
        r_out_sym  <= n_out_sym;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_hold_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_hold_v    <= n_hold_v;
            r_out_valid <= n_out_valid;
        end
    end

    `HTWD_ASSERT_NOW(a_pend_in_walk, r_pend, r_state == BK_WALK, "read pending outside walk")
    `HTWD_ASSERT_NOW(a_idle_no_hold, r_state == BK_IDLE, !r_hold_v, "symbol held while idle")
    `HTWD_ASSERT_NOW(a_mid_has_hold, r_out_valid && !r_out_last, r_hold_v,
                     "non-final symbol out with nothing held")
    `HTWD_ASSERT_NEXT(a_flush_last, r_state == BK_FLUSH && r_hold_v && w_out_free,
                      r_out_valid && r_out_last, "flush did not emit a final symbol")

endmodule

### src/huffman_tree_walk_decoder.sv
// Top level of the tree-walk Huffman decoder.
// Depends on htwd_pkg, htwd_front, htwd_queue and htwd_back.
//
// Usage:
//   Slave stream (i_s_*): each transfer is one command. tuser = 0 loads one
//   tree node entry into the slot given in tdata; tuser = 1 decodes one
//   compressed byte, most significant bit first, using its leading
//   valid_bits bits (values above 8 count as 8).
//   Master stream (o_m_*): one transfer per decoded symbol; tlast marks the
//   final symbol produced by an input byte. A byte may produce none.
//   Flow: a command passes a two-entry queue, then the walker. A load is
//   written to the node table while the walker is idle. A decode walks one
//   code bit per cycle, driven by the dependent node table read of each
//   bit, while the output does not stall it; the walker then resolves the
//   last read and a flush step releases the final symbol. Only one command
//   is in flight in the walker at a time.
//   Reset: queue and output empty. The walk position, root and node table are
//   not cleared; load every slot the code tree uses before decoding.
//   Receiver stall: the output register holds its transfer, the walker stops
//   when it must release another symbol, the queue fills and o_s_tready falls.
module huffman_tree_walk_decoder
    import htwd_pkg::*;
#(
    parameter int NODE_SLOTS = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [8:0] node_index, [9] node_is_leaf, [17:10] node_symbol, [26:18] left_index,
    // [35:27] right_index, [43:36] data_byte, [47:44] valid_bits
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // [0] mode
    input  logic                 i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [7:0] symbol
    output logic [SYM_W-1:0]     o_m_tdata,
    // last
    output logic                 o_m_tlast
);

    logic w_push;
    logic w_q_ready;
    t_cmd w_front_cmd;
    logic w_q_valid;
    logic w_pop;
    t_cmd w_q_cmd;

    // classify the incoming transfer
    htwd_front u_front (
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_data        (i_s_tdata),
        .i_mode        (i_s_tuser),
        .o_push        (w_push),
        .i_queue_ready (w_q_ready),
        .o_cmd         (w_front_cmd)
    );

    // decouple acceptance from the walk
    htwd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .i_cmd   (w_front_cmd),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd)
    );

    // carry out loads and tree walks
    htwd_back #(
        .NODE_SLOTS (NODE_SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .o_pop      (w_pop),
        .i_cmd      (w_q_cmd),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
